/* src/dpc_pkg.sv */
// ----------------------------------------------------------------------------
// dpc_pkg
// shared types, codes and constants of the directional passenger counter
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TIMER_WIDTH = 16;
  localparam int RUN_WIDTH   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TIMER_WIDTH-1:0] RETRY_PERIOD_RST = TIMER_WIDTH'(250);
  localparam logic [RUN_WIDTH-1:0]   RUN_LIMIT_RST    = RUN_WIDTH'(8);
  localparam logic [RUN_WIDTH-1:0]   TIME_STEP_RST    = RUN_WIDTH'(2);

  typedef enum logic [1:0] {
    FUNC_BEAM_A = 2'd0,
    FUNC_BEAM_B = 2'd1,
    FUNC_TICK   = 2'd2
  } dpc_func_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_BOARD  = 2'd1,
    KIND_ALIGHT = 2'd2
  } dpc_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETRY_PERIOD = 2'd0,
    CFG_RUN_LIMIT    = 2'd1,
    CFG_TIME_STEP    = 2'd2
  } dpc_cfg_idx_t;

  typedef struct packed {
    logic [TIMER_WIDTH-1:0] retry_period;
    logic [RUN_WIDTH-1:0]   run_limit;
    logic [RUN_WIDTH-1:0]   time_step;
  } dpc_cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic       beam_a_level;
    logic       beam_b_level;
  } dpc_item_t;

  typedef struct packed {
    logic                   boarding_pending;
    logic                   alighting_pending;
    logic [RUN_WIDTH-1:0]   blocked_run;
    logic                   retry_armed;
    logic [TIMER_WIDTH-1:0] retry_remaining;
    logic [COUNT_WIDTH-1:0] boarded_count;
    logic [COUNT_WIDTH-1:0] alighted_count;
    logic [COUNT_WIDTH-1:0] obstruction_time;
  } dpc_state_t;

endpackage

/* src/dpc_in_if.sv */
// ----------------------------------------------------------------------------
// dpc_in_if
// sensor event / tick item channel
// ----------------------------------------------------------------------------
interface dpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       beam_a_level;
  logic       beam_b_level;

  modport source (output valid, output func, output beam_a_level, output beam_b_level,
                  input ready);
  modport sink   (input valid, input func, input beam_a_level, input beam_b_level,
                  output ready);
endinterface

/* src/dpc_out_if.sv */
// ----------------------------------------------------------------------------
// dpc_out_if
// totals result channel
// ----------------------------------------------------------------------------
interface dpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [dpc_pkg::COUNT_WIDTH-1:0] boarded_total;
  logic [dpc_pkg::COUNT_WIDTH-1:0] alighted_total;
  logic [dpc_pkg::COUNT_WIDTH-1:0] obstruction_total;
  logic [1:0]                      passage_kind;

  modport source (output valid, output boarded_total, output alighted_total,
                  output obstruction_total, output passage_kind, input ready);
  modport sink   (input valid, input boarded_total, input alighted_total,
                  input obstruction_total, input passage_kind, output ready);
endinterface

/* src/dpc_cfg_if.sv */
// ----------------------------------------------------------------------------
// dpc_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface dpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dpc_pkg::CFG_IDX_W-1:0]  index;
  logic [dpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/dpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dpc_cfg_regs
// configuration register file, written one register per item
// ----------------------------------------------------------------------------
module dpc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  dpc_cfg_if.sink           cfg_ch,
  output dpc_pkg::dpc_cfg_t cfg
);

  dpc_pkg::dpc_cfg_t cfg_r;
  dpc_pkg::dpc_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (dpc_pkg::dpc_cfg_idx_t'(cfg_ch.index))
        dpc_pkg::CFG_RETRY_PERIOD:
          cfg_nxt.retry_period = cfg_ch.data[dpc_pkg::TIMER_WIDTH-1:0];
        dpc_pkg::CFG_RUN_LIMIT:
          cfg_nxt.run_limit = cfg_ch.data[dpc_pkg::RUN_WIDTH-1:0];
        dpc_pkg::CFG_TIME_STEP:
          cfg_nxt.time_step = cfg_ch.data[dpc_pkg::RUN_WIDTH-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_period <= dpc_pkg::RETRY_PERIOD_RST;
      cfg_r.run_limit    <= dpc_pkg::RUN_LIMIT_RST;
      cfg_r.time_step    <= dpc_pkg::TIME_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/dpc_step.sv */
// ----------------------------------------------------------------------------
// dpc_step
// next-state and result logic for one sensor event or tick
// ----------------------------------------------------------------------------
module dpc_step (
  input  dpc_pkg::dpc_item_t  item,
  input  dpc_pkg::dpc_state_t st,
  input  dpc_pkg::dpc_cfg_t   cfg,
  output dpc_pkg::dpc_state_t st_nxt,
  output dpc_pkg::dpc_kind_t  kind
);

  logic                            do_check;
  logic                            both_blocked;
  logic [dpc_pkg::RUN_WIDTH-1:0]   run_inc;

  assign both_blocked = !item.beam_a_level && !item.beam_b_level;
  assign run_inc      = st.blocked_run + dpc_pkg::RUN_WIDTH'(1);

  always_comb begin
    st_nxt   = st;
    kind     = dpc_pkg::KIND_NONE;
    do_check = 1'b0;

    unique case (dpc_pkg::dpc_func_t'(item.func))
      dpc_pkg::FUNC_BEAM_A: begin
        if (!st.boarding_pending && !st.alighting_pending) st_nxt.boarding_pending = 1'b1;
        if (st.alighting_pending) do_check = 1'b1;
      end
      dpc_pkg::FUNC_BEAM_B: begin
        if (!st.boarding_pending && !st.alighting_pending) st_nxt.alighting_pending = 1'b1;
        if (st.boarding_pending) do_check = 1'b1;
      end
      dpc_pkg::FUNC_TICK: begin
        if (st.retry_armed) begin
          if (st.retry_remaining <= dpc_pkg::TIMER_WIDTH'(1)) begin
            st_nxt.retry_remaining = '0;
            st_nxt.retry_armed     = 1'b0;
            do_check               = 1'b1;
          end else begin
            st_nxt.retry_remaining = st.retry_remaining - dpc_pkg::TIMER_WIDTH'(1);
          end
        end
      end
      default: ;  // unused selector
    endcase

    if (do_check) begin
      if (both_blocked) begin
        if (run_inc == cfg.run_limit) begin
          st_nxt.obstruction_time = st.obstruction_time
                                    + dpc_pkg::COUNT_WIDTH'(cfg.time_step);
          st_nxt.blocked_run      = '0;
        end else begin
          st_nxt.blocked_run = run_inc;
        end
        st_nxt.retry_remaining = cfg.retry_period;
        st_nxt.retry_armed     = 1'b1;
      end else begin
        if (st.boarding_pending) begin
          st_nxt.boarded_count = st.boarded_count + dpc_pkg::COUNT_WIDTH'(1);
          kind                 = dpc_pkg::KIND_BOARD;
        end
        if (st.alighting_pending) begin
          st_nxt.alighted_count = st.alighted_count + dpc_pkg::COUNT_WIDTH'(1);
          kind                  = dpc_pkg::KIND_ALIGHT;
        end
        st_nxt.blocked_run       = '0;
        st_nxt.boarding_pending  = 1'b0;
        st_nxt.alighting_pending = 1'b0;
      end
    end
  end

endmodule

/* src/directional_passenger_counter_core.sv */
// ----------------------------------------------------------------------------
// directional_passenger_counter_core
// two-beam door passenger counter: boardings, alightings, obstruction time
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  in_ch     in   valid / ready     func, beam_a_level, beam_b_level
//  out_ch    out  valid / ready     boarded/alighted/obstruction totals, kind
//  cfg_ch    in   valid / ready     index, data (always ready)
//
//  one item per cycle sustained while the output is not stalled; an item
//  waits in the input register and is then folded into the counter state
//  as it moves to the output register, from which the result is offered
//  the state update is the single combinational step between those registers
//  a stalled output holds the input register; input stays ready while the
//  input register is empty or moving on
//  synchronous active-low reset: counters and flags to zero, registers to
//  their default values, both pipeline registers empty
//
module directional_passenger_counter_core (
  input  logic      clk,
  input  logic      rst_n,
  dpc_in_if.sink    in_ch,
  dpc_out_if.source out_ch,
  dpc_cfg_if.sink   cfg_ch
);

  // configuration
  dpc_pkg::dpc_cfg_t cfg;

  dpc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input register
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  dpc_pkg::dpc_item_t s1_item_r;
  logic               s1_advance;
  logic               in_fire;

  // counter state
  dpc_pkg::dpc_state_t st_r;
  dpc_pkg::dpc_state_t st_nxt;
  dpc_pkg::dpc_state_t step_st;
  dpc_pkg::dpc_kind_t  step_kind;

  // output register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  dpc_pkg::dpc_kind_t     out_kind_r;
  logic [dpc_pkg::COUNT_WIDTH-1:0] out_boarded_r;
  logic [dpc_pkg::COUNT_WIDTH-1:0] out_alighted_r;
  logic [dpc_pkg::COUNT_WIDTH-1:0] out_obstr_r;

  // the input register moves on when the output register is free or draining
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_advance);
  assign out_valid_nxt = s1_advance || (out_valid_r && !out_ch.ready);

  dpc_step u_step (
    .item   (s1_item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (step_st),
    .kind   (step_kind)
  );

  // state only changes when an item is folded in
  assign st_nxt = s1_advance ? step_st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func         <= in_ch.func;
      s1_item_r.beam_a_level <= in_ch.beam_a_level;
      s1_item_r.beam_b_level <= in_ch.beam_b_level;
    end
    if (s1_advance) begin
      out_kind_r     <= step_kind;
      out_boarded_r  <= step_st.boarded_count;
      out_alighted_r <= step_st.alighted_count;
      out_obstr_r    <= step_st.obstruction_time;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.boarded_total     = out_boarded_r;
  assign out_ch.alighted_total    = out_alighted_r;
  assign out_ch.obstruction_total = out_obstr_r;
  assign out_ch.passage_kind      = out_kind_r;

`ifndef ASSERT_OFF
  // at most one passage direction is ever pending
  a_single_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.boarding_pending && st_r.alighting_pending))
    else $error("both passage directions pending");

  // a disarmed retry timer holds zero
  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.retry_armed |-> (st_r.retry_remaining == '0))
    else $error("retry timer count left behind while disarmed");

  // a stalled output freezes the counter state
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(st_r))
    else $error("state changed while output stalled");

  // a counted boarding bumps the boarding total by one
  a_board_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && (step_kind == dpc_pkg::KIND_BOARD)) |=>
      (st_r.boarded_count == $past(st_r.boarded_count) + dpc_pkg::COUNT_WIDTH'(1)))
    else $error("boarding counted without increment");
`endif

endmodule
